// ===== rtl/core/lr_pkg.sv =====
// Package for the line rasteriser: widths, item structs, controller states
// and the command and status structs between controller and datapath.
// It depends on nothing else.
package lr_pkg;

  localparam int COORD_BITS = 6;
  // The decision value needs one bit of headroom beyond twice a coordinate, plus sign.
  localparam int D_W = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [D_W-1:0] dec_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ORDER,
    ST_PREP,
    ST_RUN
  } lr_state_t;

  typedef struct packed {
    logic load;   // capture the accepted command
    logic order;  // swap endpoints and form the deltas
    logic prep;   // choose the octant and seed the decision value
    logic step;   // advance to the next pixel
  } lr_cmd_t;

  typedef struct packed {
    logic last;   // the pixel on show ends the run
  } lr_status_t;

endpackage

// ===== rtl/core/lr_ctrl.sv =====
// Controller for the line rasteriser: sequences load, set-up and the pixel run.
// Depends on lr_pkg.
module lr_ctrl import lr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  lr_status_t status,
  output lr_cmd_t    cmd
);

  lr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ORDER;
        end
      end
      ST_ORDER: state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_RUN;
      ST_RUN: begin
        if (!out_stall && status.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_ORDER: cmd.order = 1'b1;
      ST_PREP:  cmd.prep = 1'b1;
      ST_RUN: begin
        out_valid = 1'b1;
        cmd.step  = !out_stall && !status.last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall))
    else $error("command taken while a run is on show");

  a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_ORDER))
    else $error("accepted command not followed by set-up");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled pixel withdrawn");
`endif

endmodule

// ===== rtl/core/lr_datapath.sv =====
// Datapath for the line rasteriser: endpoint registers, octant set-up,
// decision value and pixel position. Depends on lr_pkg.
module lr_datapath import lr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  lr_cmd_t    cmd,
  output lr_status_t status,
  output out_item_t  out_item
);

  coord_t                      x0_r, y0_r, x1_r, y1_r;
  coord_t                      x0_nxt, y0_nxt, x1_nxt, y1_nxt;
  coord_t                      x_r, y_r, x_nxt, y_nxt;
  coord_t                      dx_r, dx_nxt;
  logic signed [COORD_BITS:0]  dy_r, dy_nxt;
  coord_t                      cnt_r, cnt_nxt;
  dec_t                        d_r, d_nxt, inc_ax_r, inc_ax_nxt, inc_dg_r, inc_dg_nxt;
  logic                        xmajor_r, xmajor_nxt, yneg_r, yneg_nxt;
  coord_t                      ady, major, minor;
  logic signed [COORD_BITS:0]  dy_neg;
  logic                        axial;

  assign dy_neg = -dy_r;
  assign ady    = dy_r[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy_r[COORD_BITS-1:0];
  assign major  = (ady <= dx_r) ? dx_r : ady;
  assign minor  = (ady <= dx_r) ? ady : dx_r;
  assign axial  = d_r[D_W-1] || (d_r == '0);

  always_comb begin
    x0_nxt = x0_r; y0_nxt = y0_r; x1_nxt = x1_r; y1_nxt = y1_r;
    x_nxt = x_r; y_nxt = y_r; dx_nxt = dx_r; dy_nxt = dy_r; cnt_nxt = cnt_r;
    d_nxt = d_r; inc_ax_nxt = inc_ax_r; inc_dg_nxt = inc_dg_r;
    xmajor_nxt = xmajor_r; yneg_nxt = yneg_r;
    if (cmd.load) begin
      x0_nxt = in_item.start_x;
      y0_nxt = in_item.start_y;
      x1_nxt = in_item.end_x;
      y1_nxt = in_item.end_y;
    end
    if (cmd.order) begin
      if (x0_r > x1_r) begin
        x_nxt  = x1_r;
        y_nxt  = y1_r;
        dx_nxt = x0_r - x1_r;
        dy_nxt = $signed({1'b0, y0_r}) - $signed({1'b0, y1_r});
      end else begin
        x_nxt  = x0_r;
        y_nxt  = y0_r;
        dx_nxt = x1_r - x0_r;
        dy_nxt = $signed({1'b0, y1_r}) - $signed({1'b0, y0_r});
      end
    end
    if (cmd.prep) begin
      xmajor_nxt = (ady <= dx_r);
      yneg_nxt   = dy_r[COORD_BITS];
      cnt_nxt    = major;
      inc_ax_nxt = $signed({2'b00, minor, 1'b0});
      inc_dg_nxt = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
      d_nxt      = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
    end
    if (cmd.step) begin
      cnt_nxt = cnt_r - 1'b1;
      if (axial) begin
        d_nxt = d_r + inc_ax_r;
        if (xmajor_r) begin
          x_nxt = x_r + 1'b1;
        end else begin
          y_nxt = yneg_r ? y_r - 1'b1 : y_r + 1'b1;
        end
      end else begin
        d_nxt = d_r + inc_dg_r;
        x_nxt = x_r + 1'b1;
        y_nxt = yneg_r ? y_r - 1'b1 : y_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= x0_nxt; y0_r <= y0_nxt; x1_r <= x1_nxt; y1_r <= y1_nxt;
    x_r <= x_nxt; y_r <= y_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt; cnt_r <= cnt_nxt;
    d_r <= d_nxt; inc_ax_r <= inc_ax_nxt; inc_dg_r <= inc_dg_nxt;
    xmajor_r <= xmajor_nxt; yneg_r <= yneg_nxt;
  end

  assign status.last      = (cnt_r == '0);
  assign out_item.pixel_x = x_r;
  assign out_item.pixel_y = y_r;
  assign out_item.last    = status.last;

`ifndef SYNTHESIS
  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cmd.step) |-> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("pixel count did not step down");

  a_x_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cmd.step) |-> (x_r == $past(x_r) || x_r == $past(x_r) + 1'b1))
    else $error("column moved by more than one");

  // The position registers hold no value until the first command is set up.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cmd.step) && !$past(cmd.order) &&
    !$isunknown($past({x_r, y_r})) |-> $stable(x_r) && $stable(y_r))
    else $error("pixel position changed without a step");
`endif

endmodule

// ===== rtl/core/line_rasterizer.sv =====
// Line rasteriser: an accepted command steps through the controller states ST_ORDER
// and ST_PREP, and its first pixel is on show in ST_RUN. A line of n pixels
// (n = max(|dx|,|dy|)+1) then streams one pixel per cycle while out_stall is low,
// and the next command is taken once the controller is back in ST_IDLE after the
// last pixel leaves. Reset (rst_n low, synchronous) returns the controller to idle;
// no run is kept. Depends on lr_pkg, lr_ctrl and lr_datapath.
module line_rasterizer import lr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // The controller and datapath speak only through these two structs.
  lr_cmd_t    cmd;
  lr_status_t status;

  // The controller takes one item at a time: it stalls the input from the
  // moment an item is accepted until the final pixel of its run is taken.
  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath swaps the endpoints when needed, picks the octant, then
  // holds the pixel on show in its position registers, which act as the
  // output register, so a stalled pixel stays put until taken.
  lr_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

// ===== tb/tb_line_rasterizer.sv =====
// Self-checking testbench for line_rasterizer: directed and random line commands,
// each pixel run checked against a midpoint-rule line plotter kept in the bench.
// Depends on lr_pkg and the line_rasterizer RTL.
`timescale 1ns / 100ps

module tb_line_rasterizer;
  import lr_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 288;
  // From this random item on, neither side idles.
  localparam int QUIET_FROM   = 250;
  // Before this random item the sender waits for the pipeline to drain.
  localparam int DRAIN_AT     = 150;
  localparam int IDLE_LIMIT   = 500;
  localparam int TAIL_CYCLES  = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int MAX_COORD    = (1 << COORD_BITS) - 1;
  localparam int NUM_ROWS     = 22;

  // One row of the directed table. Where has_pix is set, the run is a single
  // pixel whose value is typed in; all other rows go through the plotter.
  typedef struct packed {
    in_item_t  cmd;
    logic      has_pix;
    out_item_t pix;
  } cmd_row_t;

  localparam out_item_t NO_PIX = '0;

  localparam cmd_row_t DIRECTED [NUM_ROWS] = '{
    // Equal endpoints: a single pixel marked last.
    '{'{6'd0,  6'd0,  6'd0,  6'd0},  1'b1, '{6'd0,  6'd0,  1'b1}},
    '{'{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, '{6'd63, 6'd63, 1'b1}},
    '{'{6'd21, 6'd42, 6'd21, 6'd42}, 1'b1, '{6'd21, 6'd42, 1'b1}},
    // Full-width horizontal runs, both directions.
    '{'{6'd0,  6'd0,  6'd63, 6'd0},  1'b0, NO_PIX},
    '{'{6'd63, 6'd0,  6'd0,  6'd0},  1'b0, NO_PIX},
    // Equal columns: no swap, the run goes down or up from the start.
    '{'{6'd0,  6'd0,  6'd0,  6'd63}, 1'b0, NO_PIX},
    '{'{6'd0,  6'd63, 6'd0,  6'd0},  1'b0, NO_PIX},
    // Slope of exactly one in either sense, with and without a swap.
    '{'{6'd0,  6'd0,  6'd63, 6'd63}, 1'b0, NO_PIX},
    '{'{6'd63, 6'd0,  6'd0,  6'd63}, 1'b0, NO_PIX},
    '{'{6'd0,  6'd63, 6'd63, 6'd0},  1'b0, NO_PIX},
    '{'{6'd63, 6'd63, 6'd0,  6'd0},  1'b0, NO_PIX},
    // One of each octant case: shallow and steep, rising and falling.
    '{'{6'd10, 6'd10, 6'd20, 6'd14}, 1'b0, NO_PIX},
    '{'{6'd10, 6'd10, 6'd20, 6'd6},  1'b0, NO_PIX},
    '{'{6'd10, 6'd10, 6'd14, 6'd20}, 1'b0, NO_PIX},
    '{'{6'd10, 6'd10, 6'd14, 6'd0},  1'b0, NO_PIX},
    '{'{6'd20, 6'd14, 6'd10, 6'd10}, 1'b0, NO_PIX},
    // Decision value landing on zero, which must take the axial step.
    '{'{6'd5,  6'd5,  6'd9,  6'd7},  1'b0, NO_PIX},
    '{'{6'd0,  6'd0,  6'd2,  6'd1},  1'b0, NO_PIX},
    '{'{6'd0,  6'd0,  6'd1,  6'd2},  1'b0, NO_PIX},
    // Alternating bit patterns and a short swapped diagonal.
    '{'{6'd42, 6'd21, 6'd21, 6'd42}, 1'b0, NO_PIX},
    '{'{6'd1,  6'd0,  6'd0,  6'd1},  1'b0, NO_PIX},
    '{'{6'd0,  6'd32, 6'd63, 6'd31}, 1'b0, NO_PIX}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Pixels still owed by the block, oldest first.
  out_item_t pending_pixels [$];
  int        mismatches;
  int        idle_cycles;
  int        stall_left;
  bit        quiet;

  line_rasterizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Works out the pixel run of one line command by the midpoint rule and
  // queues it. Endpoints given right to left are swapped first, so x never
  // falls along the run; a decision value of zero or below steps axially.
  task automatic plot_line(input in_item_t c);
    int x0, y0, x1, y1, t;
    int dx, dy, ady, sy, d, inc_ax, inc_dg, steps, x, y;
    bit xmajor;
    out_item_t p;
    x0 = c.start_x;
    y0 = c.start_y;
    x1 = c.end_x;
    y1 = c.end_y;
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    sy = (dy >= 0) ? 1 : -1;
    ady = (dy >= 0) ? dy : -dy;
    xmajor = (ady <= dx);
    if (xmajor) begin
      d = 2 * ady - dx;
      inc_ax = 2 * ady;
      inc_dg = 2 * (ady - dx);
      steps = dx;
    end else begin
      d = 2 * dx - ady;
      inc_ax = 2 * dx;
      inc_dg = 2 * (dx - ady);
      steps = ady;
    end
    x = x0;
    y = y0;
    p.pixel_x = coord_t'(x);
    p.pixel_y = coord_t'(y);
    p.last = (steps == 0);
    pending_pixels.push_back(p);
    for (int i = 0; i < steps; i++) begin
      if (d <= 0) begin
        d += inc_ax;
        if (xmajor) x += 1;
        else y += sy;
      end else begin
        d += inc_dg;
        x += 1;
        y += sy;
      end
      p.pixel_x = coord_t'(x);
      p.pixel_y = coord_t'(y);
      p.last = (i == steps - 1);
      pending_pixels.push_back(p);
    end
  endtask

  // Offers one command, after an occasional idle burst, and returns at the
  // rising edge where the block takes it. The caller queues what it expects.
  task automatic send_cmd(input in_item_t c);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= c;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic coord_t near_coord(input int base, input int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return coord_t'(v);
  endfunction

  // Random commands: mostly short lines around a random point, which keeps
  // the run quick while every coordinate bit still toggles; some lines span
  // the whole grid, and the rest are degenerate shapes or diagonals.
  function automatic in_item_t random_cmd();
    in_item_t c;
    int pick;
    int len;
    pick = $urandom_range(0, 19);
    c.start_x = coord_t'($urandom);
    c.start_y = coord_t'($urandom);
    if (pick < 12) begin
      c.end_x = near_coord(c.start_x, 8);
      c.end_y = near_coord(c.start_y, 8);
    end else if (pick < 16) begin
      c.end_x = coord_t'($urandom);
      c.end_y = coord_t'($urandom);
    end else if (pick == 16) begin
      c.end_x = c.start_x;
      c.end_y = c.start_y;
    end else if (pick == 17) begin
      c.end_x = c.start_x;
      c.end_y = coord_t'($urandom);
    end else if (pick == 18) begin
      c.end_x = coord_t'($urandom);
      c.end_y = c.start_y;
    end else begin
      // A diagonal of random length and direction, kept inside the grid.
      len = $urandom_range(0, 12);
      c.end_x = near_coord(c.start_x + ($urandom_range(0, 1) ? len : -len), 0);
      len = (c.end_x > c.start_x) ? c.end_x - c.start_x : c.start_x - c.end_x;
      if ($urandom_range(0, 1) && c.start_y + len <= MAX_COORD)
        c.end_y = coord_t'(c.start_y + len);
      else if (c.start_y >= len)
        c.end_y = coord_t'(c.start_y - len);
      else
        c.end_y = coord_t'(c.start_y + len);
    end
    return c;
  endfunction

  // The receiver stalls in random bursts, and not at all once the run is quiet.
  always @(negedge clk) begin : stall_gen
    logic nxt;
    if (quiet) begin
      stall_left = 0;
      nxt = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      nxt = 1'b1;
    end else begin
      nxt = 1'b0;
    end
    out_stall <= nxt;
  end

  // Every accepted pixel is compared with the oldest one owed.
  always @(posedge clk) begin : pixel_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected pixel x=%0d y=%0d last=%0b",
                   out_item.pixel_x, out_item.pixel_y, out_item.last);
      end else begin
        want = pending_pixels.pop_front();
        if (out_item.pixel_x !== want.pixel_x || out_item.pixel_y !== want.pixel_y ||
            out_item.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     want.pixel_x, want.pixel_y, want.last,
                     out_item.pixel_x, out_item.pixel_y, out_item.last);
        end
      end
    end
  end

  // Watchdog: a long spell with no item moving on either channel means the
  // block has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    out_stall   = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    stall_left  = 0;
    quiet       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: typed single pixels where the answer is obvious,
    // everything else through the plotter.
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_cmd(DIRECTED[r].cmd);
      if (DIRECTED[r].has_pix)
        pending_pixels.push_back(DIRECTED[r].pix);
      else
        plot_line(DIRECTED[r].cmd);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin : random_part
      in_item_t c;
      if (n == 0 || n == DRAIN_AT) begin
        // Hold off until every owed pixel has come out.
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
      end
      if (n == QUIET_FROM) quiet = 1'b1;
      c = random_cmd();
      send_cmd(c);
      plot_line(c);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== line_rasterizer.f =====
rtl/core/lr_pkg.sv
rtl/core/lr_ctrl.sv
rtl/core/lr_datapath.sv
rtl/core/line_rasterizer.sv
tb/tb_line_rasterizer.sv
